// ===== hw/rtl/balanced_ternary_encoder_top_macros.svh =====
// Assertion macros shared by the balanced-ternary encoder RTL.
`ifndef BALANCED_TERNARY_ENCODER_TOP_MACROS_SVH
`define BALANCED_TERNARY_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BTENC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define BTENC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/btenc_pkg.sv =====
// Shared constants and types for the balanced-ternary encoder.
`timescale 1ns / 1ps

package btenc_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int MAX_TRITS_DEF  = 21;
	localparam int MUL_SLICE      = 32;
	localparam int TRIT_BITS      = 2;

	localparam logic [TRIT_BITS-1:0] TRIT_ZERO = 2'b00;
	localparam logic [TRIT_BITS-1:0] TRIT_POS  = 2'b01;
	localparam logic [TRIT_BITS-1:0] TRIT_NEG  = 2'b11;
	localparam logic [TRIT_BITS-1:0] TRIT_BAD  = 2'b10;

	localparam logic [1:0] REM_ZERO = 2'd0;
	localparam logic [1:0] REM_ONE  = 2'd1;
	localparam logic [1:0] REM_TWO  = 2'd2;
	localparam logic [1:0] REM_BAD  = 2'd3;

	typedef struct packed {
		logic       done;
		logic [1:0] rem;
	} div_stat_t;

endpackage

// ===== hw/rtl/btenc_ifs.sv =====
// Valid/ready channel interfaces for the encoder input and digit output.
`timescale 1ns / 1ps

interface btenc_val_if #(
	parameter int W = btenc_pkg::VALUE_BITS_DEF
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface btenc_trit_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [btenc_pkg::TRIT_BITS-1:0] trit;
	logic                                   last;

	modport source (output valid, output trit, output last, input ready);
	modport sink (input valid, input trit, input last, output ready);
endinterface

// ===== hw/rtl/btenc_div3.sv =====
// Shared divide-by-3 step unit: reciprocal multiply in 32-bit slices, then fix-up.
`timescale 1ns / 1ps
`include "balanced_ternary_encoder_top_macros.svh"

module btenc_div3 #(
	parameter int VALUE_BITS = btenc_pkg::VALUE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [VALUE_BITS-1:0]    mag,
	output btenc_pkg::div_stat_t     stat,
	output logic [VALUE_BITS-1:0]    q_next
);

	localparam int W      = VALUE_BITS;
	localparam int S      = btenc_pkg::MUL_SLICE;
	localparam int PASSES = (W + S - 1) / S;
	localparam int RW     = PASSES * S;
	localparam int AW     = W + RW;
	localparam int PW     = (PASSES > 1) ? $clog2(PASSES) : 1;
	localparam int ADJ    = ((W + 1) % 2 == 1) ? 1 : 2;

	// ceil(2^(W+1) / 3): floor(m * RECIP / 2^(W+1)) == floor(m / 3) for m < 2^W
	localparam logic [W+1:0] POW2    = (W + 2)'(1) << (W + 1);
	localparam logic [W+1:0] RECIP_W = (POW2 + (W + 2)'(ADJ)) / (W + 2)'(3);
	localparam logic [RW-1:0] RECIP  = RW'(RECIP_W);

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_MUL  = 3'b010,
		PH_FIN  = 3'b100
	} phase_t;

	phase_t         ph_q;
	logic [PW-1:0]  pass_q;
	logic [AW-1:0]  acc_q;

	logic [PW-1:0]  pass_idx;
	logic [S-1:0]   slice;
	logic [W+S-1:0] prod;
	logic [AW-1:0]  part;
	logic [W-1:0]   quo;
	logic [1:0]     rem;

	always_comb begin
		pass_idx = (ph_q == PH_MUL) ? pass_q : '0;
		slice    = RECIP[int'(pass_idx) * S +: S];
		prod     = {{S{1'b0}}, mag} * {{W{1'b0}}, slice};
		part     = AW'(prod) << (int'(pass_idx) * S);
		quo      = W'(acc_q >> (W + 1));
		rem      = mag[1:0] - (quo[1:0] + {quo[0], 1'b0});
		q_next   = quo + W'(rem == btenc_pkg::REM_TWO);
		stat.done = (ph_q == PH_FIN);
		stat.rem  = rem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			pass_q <= '0;
		end else begin
			case (ph_q)
				PH_IDLE: begin
					if (start) begin
						if (PASSES == 1) begin
							ph_q <= PH_FIN;
						end else begin
							pass_q <= PW'(1);
							ph_q   <= PH_MUL;
						end
					end
				end
				PH_MUL: begin
					if (pass_q == PW'(PASSES - 1)) begin
						ph_q <= PH_FIN;
					end else begin
						pass_q <= pass_q + PW'(1);
					end
				end
				PH_FIN: begin
					ph_q <= PH_IDLE;
				end
				default: begin
					ph_q <= PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ph_q == PH_IDLE && start) begin
			acc_q <= part;
		end else if (ph_q == PH_MUL) begin
			acc_q <= acc_q + part;
		end
	end

	`BTENC_ASSERT_IMP(a_start_idle, start, ph_q == PH_IDLE, "divider started while busy")
	`BTENC_ASSERT_IMP(a_rem_range, stat.done, stat.rem != btenc_pkg::REM_BAD, "remainder of 3")
	`BTENC_ASSERT_NEXT(a_done_pulse, stat.done, !stat.done, "done held over two cycles")

endmodule

// ===== hw/rtl/balanced_ternary_encoder_top.sv =====
// Balanced-ternary encoder: signed integer in, run of trits out, most significant first.
// One value is taken while the block is idle (value_ch.ready high). Its magnitude is
// divided by 3 in a shared reciprocal-multiply unit, one digit per divide; each digit is
// held in a small store, then the digits leave most significant first at one per cycle
// while trit_ch.ready stays high, through an output register, the last one flagged. At
// most MAX_TRITS trits are sent per value (21 at 32 bits); zero gives the single trit 0.
// Negative inputs have every digit negated; if MAX_TRITS is below what the magnitude
// needs, only the MAX_TRITS least significant digits are sent. trit codes: 0 = 2'b00,
// +1 = 2'b01, -1 = 2'b11.
`timescale 1ns / 1ps
`include "balanced_ternary_encoder_top_macros.svh"

module balanced_ternary_encoder_top #(
	parameter int VALUE_BITS = btenc_pkg::VALUE_BITS_DEF,
	parameter int MAX_TRITS  = btenc_pkg::MAX_TRITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	btenc_val_if.sink    value_ch,
	btenc_trit_if.source trit_ch
);

	localparam int W     = VALUE_BITS;
	localparam int IDX_W = $clog2(MAX_TRITS);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t                          st_q;
	logic                            start_q;
	logic [W-1:0]                    mag_q;
	logic                            neg_q;
	logic [IDX_W-1:0]                cnt_q;
	logic [IDX_W-1:0]                rd_q;
	logic                            out_valid_q;
	logic [btenc_pkg::TRIT_BITS-1:0] out_trit_q;
	logic                            out_last_q;
	logic [btenc_pkg::TRIT_BITS-1:0] store_q [MAX_TRITS];

	btenc_pkg::div_stat_t            stat;
	logic [W-1:0]                    q_next;
	logic [W-1:0]                    vu;
	logic [W-1:0]                    mag_in;
	logic                            fire;
	logic                            load;
	logic [btenc_pkg::TRIT_BITS-1:0] digit;

	btenc_div3 #(
		.VALUE_BITS(VALUE_BITS)
	) u_div3 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.mag    (mag_q),
		.stat   (stat),
		.q_next (q_next)
	);

	assign value_ch.ready = (st_q == ST_IDLE);
	assign fire           = value_ch.valid && value_ch.ready;
	assign load           = (st_q == ST_EMIT) && (!out_valid_q || trit_ch.ready);

	assign trit_ch.valid = out_valid_q;
	assign trit_ch.trit  = $signed(out_trit_q);
	assign trit_ch.last  = out_last_q;

	always_comb begin
		vu     = value_ch.value;
		mag_in = vu[W-1] ? (~vu + W'(1)) : vu;
		case (stat.rem)
			btenc_pkg::REM_ONE: digit = neg_q ? btenc_pkg::TRIT_NEG : btenc_pkg::TRIT_POS;
			btenc_pkg::REM_TWO: digit = neg_q ? btenc_pkg::TRIT_POS : btenc_pkg::TRIT_NEG;
			default:            digit = btenc_pkg::TRIT_ZERO;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			start_q <= 1'b0;
			mag_q   <= '0;
			neg_q   <= 1'b0;
			cnt_q   <= '0;
			rd_q    <= '0;
		end else begin
			start_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (fire) begin
						neg_q <= vu[W-1];
						mag_q <= mag_in;
						cnt_q <= '0;
						if (mag_in == '0) begin
							rd_q <= '0;
							st_q <= ST_EMIT;
						end else begin
							start_q <= 1'b1;
							st_q    <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (stat.done) begin
						mag_q <= q_next;
						cnt_q <= cnt_q + IDX_W'(1);
						if (q_next == '0 || cnt_q == IDX_W'(MAX_TRITS - 1)) begin
							rd_q <= cnt_q;
							st_q <= ST_EMIT;
						end else begin
							start_q <= 1'b1;
						end
					end
				end
				ST_EMIT: begin
					if (load) begin
						if (rd_q == '0) begin
							st_q <= ST_IDLE;
						end else begin
							rd_q <= rd_q - IDX_W'(1);
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (trit_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// digit store, least significant first
	always_ff @(posedge clk) begin
		if (fire && mag_in == '0) begin
			store_q[0] <= btenc_pkg::TRIT_ZERO;
		end else if (st_q == ST_DIV && stat.done) begin
			store_q[cnt_q] <= digit;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_trit_q <= store_q[rd_q];
			out_last_q <= (rd_q == '0);
		end
	end

	`BTENC_ASSERT_IMP(a_done_in_div, stat.done, st_q == ST_DIV, "divider done outside divide")
	`BTENC_ASSERT_NEXT(a_last_left_emit, load && rd_q == '0, st_q == ST_IDLE, "emit after last")
	`BTENC_ASSERT_IMP(a_start_in_div, start_q, st_q == ST_DIV && !stat.done, "stray divider start")

endmodule

// ===== verif/balanced_ternary_encoder_top_test.sv =====
// Self-checking testbench for the balanced-ternary encoder: signed values in, trit runs checked.
`timescale 1ns / 1ps

module balanced_ternary_encoder_top_test;

	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 100;
	localparam int RANDOM_ITEMS = 300;
	localparam int MAX_REPORTS = 10;

	localparam logic [btenc_pkg::VALUE_BITS_DEF-1:0] CORNER_VALUES [23] = '{
		0, 1, -1, 2, -2, 3, -3, 4, 5, 13, -13, 40, -40,
		32'h7FFFFFFF, 32'h80000000, 32'h80000001,
		1743392200, 1743392201, -1743392200, -1743392201,
		1162261467, 32'h55555555, 32'hAAAAAAAA
	};

	typedef struct packed {
		logic [btenc_pkg::TRIT_BITS-1:0] trit;
		logic                            last;
	} trit_result_t;

	class trit_scoreboard;
		trit_result_t expected_trits[$];
		int unsigned  failures;

		function logic [btenc_pkg::TRIT_BITS-1:0] trit_code(int d);
			if (d < 0)
				return btenc_pkg::TRIT_NEG;
			else if (d == 0)
				return btenc_pkg::TRIT_ZERO;
			return btenc_pkg::TRIT_POS;
		endfunction

		function void note_value(logic [btenc_pkg::VALUE_BITS_DEF-1:0] v);
			logic [btenc_pkg::VALUE_BITS_DEF-1:0] mag;
			logic [1:0]                           rem;
			logic                                 neg;
			int                                   digits[btenc_pkg::MAX_TRITS_DEF];
			int                                   count;
			int                                   d;
			trit_result_t                         res;
			neg = v[btenc_pkg::VALUE_BITS_DEF-1];
			mag = neg ? (~v + 1'b1) : v;
			count = 0;
			if (mag == '0) begin
				digits[0] = 0;
				count = 1;
			end
			while (mag != '0 && count < btenc_pkg::MAX_TRITS_DEF) begin
				rem = 2'(mag % 3);
				mag = mag / 3;
				if (rem == btenc_pkg::REM_TWO) begin
					d = -1;
					mag = mag + 1'b1;
				end else begin
					d = int'(rem);
				end
				digits[count] = neg ? -d : d;
				count++;
			end
			for (int k = count - 1; k >= 0; k--) begin
				res.trit = trit_code(digits[k]);
				res.last = (k == 0);
				expected_trits.push_back(res);
			end
		endfunction

		function void report(string msg);
			failures++;
			if (failures <= MAX_REPORTS)
				$display("%0t: %s", $realtime, msg);
		endfunction

		function void check_trit(logic [btenc_pkg::TRIT_BITS-1:0] trit, logic last);
			trit_result_t exp_res;
			if (expected_trits.size() == 0) begin
				report($sformatf("unexpected trit %0d last %0b",
					$signed(trit), last));
				return;
			end
			exp_res = expected_trits.pop_front();
			if (exp_res.trit !== trit || exp_res.last !== last)
				report($sformatf("trit mismatch: expected trit %0d last %0b, got trit %0d last %0b",
					$signed(exp_res.trit), exp_res.last, $signed(trit), last));
		endfunction

		function int pending();
			return expected_trits.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic src_calm = 1'b0;
	logic snk_calm = 1'b0;
	int unsigned idle_cycles = 0;
	trit_scoreboard sb;

	btenc_val_if #(.W(btenc_pkg::VALUE_BITS_DEF)) value_ch ();
	btenc_trit_if trit_ch ();

	balanced_ternary_encoder_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.value_ch (value_ch),
		.trit_ch  (trit_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function int draw_gap(logic calm);
		return calm ? 0 : $urandom_range(0, 16);
	endfunction

	function logic [btenc_pkg::VALUE_BITS_DEF-1:0] next_value();
		logic [btenc_pkg::VALUE_BITS_DEF-1:0] p;
		p = 1;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: p = $urandom;
			5, 6: p = $urandom_range(0, 200) - 100;
			7, 8: begin
				repeat ($urandom_range(0, 20)) p = p * 3;
				p = p + $urandom_range(0, 4) - 2;
				if ($urandom_range(0, 1))
					p = -p;
			end
			default: begin
				if ($urandom_range(0, 1))
					p = 32'h80000000 + $urandom_range(0, 3);
				else
					p = 32'h7FFFFFFF - $urandom_range(0, 3);
			end
		endcase
		return p;
	endfunction

	task automatic send_value(input logic [btenc_pkg::VALUE_BITS_DEF-1:0] v);
		int gap;
		gap = draw_gap(src_calm);
		if (gap > 0) begin
			value_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		value_ch.valid <= 1'b1;
		value_ch.value <= v;
		do @(posedge clk); while (!value_ch.ready);
		sb.note_value(v);
	endtask

	task automatic wait_for_drain();
		value_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// watchdog: cycles with no item accepted on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((value_ch.valid && value_ch.ready) || (trit_ch.valid && trit_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin : trit_sink
		int gap;
		trit_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			gap = draw_gap(snk_calm);
			if (gap > 0) begin
				trit_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			trit_ch.ready <= 1'b1;
			do @(posedge clk); while (!trit_ch.valid);
			sb.check_trit(trit_ch.trit, trit_ch.last);
		end
	end

	initial begin : value_source
		sb = new();
		value_ch.valid <= 1'b0;
		value_ch.value <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (CORNER_VALUES[i])
			send_value(CORNER_VALUES[i]);
		// hold off until the whole backlog is out
		wait_for_drain();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) begin
				src_calm = ($urandom_range(0, 3) == 0);
				snk_calm = ($urandom_range(0, 3) == 0);
			end
			if (n == RANDOM_ITEMS / 2)
				wait_for_drain();
			send_value(next_value());
		end
		value_ch.valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
